// ===== rtl/lidar_bev_occupancy_grid_unit_macros.svh =====
// Assertion macros shared by the occupancy grid RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LIDAR_BEV_OCCUPANCY_GRID_UNIT_MACROS_SVH
`define LIDAR_BEV_OCCUPANCY_GRID_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LBEV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbev: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define LBEV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbev: assertion failed");
`else
`define LBEV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LBEV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lbev_pkg.sv =====
// Shared widths, codes, reset values and types of the occupancy grid unit.
// No dependencies; imported by the top level.
package lbev_pkg;

    // Field and register widths.
    localparam int FUNC_W     = 2;
    localparam int POS_W      = 16;
    localparam int ROW_W      = 6;
    localparam int BITS_W     = 64;
    localparam int CELLS_W    = 7;
    localparam int RANGE_W    = 15;
    localparam int SCALE_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Datapath widths: position plus range, its magnitude, and the scaled product.
    localparam int SUM_W      = POS_W + 1;
    localparam int MAG_W      = POS_W;
    localparam int PROD_W     = MAG_W + SCALE_W;
    localparam int SCALE_FRAC = 24;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_CELLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE   = 2'd2;

    // Register values after reset.
    localparam logic [CELLS_W-1:0] GRID_CELLS_RST   = 7'd64;
    localparam logic [RANGE_W-1:0] RANGE_OFFSET_RST = 15'd12800;
    localparam logic [SCALE_W-1:0] CELL_SCALE_RST   = 24'd41943;

    // Operation fields held while an item is in flight.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ROW_W-1:0]  read_row;
    } t_item;

endpackage

// ===== rtl/lbev_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; used for the occupancy row store.
module lbev_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lidar_bev_occupancy_grid_unit.sv =====
// Bird's-eye-view occupancy grid: bins points into a square grid of single-bit cells.
// Uses lbev_pkg, lbev_ram and lidar_bev_occupancy_grid_unit_macros.svh.
//
// Usage:
//   The input channel (i_in_valid / o_in_stall) carries one operation per transfer:
//   clear the grid, mark a point, or read one row bitmap. Every operation gives
//   exactly one result on the output channel (o_out_valid / i_out_stall).
//   An item goes through these steps: accept registers position plus range as sign
//   and magnitude, ST_MUL registers the two 16x24 products, ST_IDX reads the row
//   from the occupancy memory, and ST_WB merges the cell bit, writes the row back
//   and loads the output register. No new item is taken until ST_WB is left, as the
//   read-modify-write goes through the single row memory, which one item owns at a
//   time. The output register lets the next item be taken while a result waits.
//   If the receiver stalls, the finished item waits in its last step and the
//   block takes no new item until the output register frees up.
//   A clear takes effect in one step through per-row valid flags; no memory sweep.
//   Configuration writes (i_cfg_valid / o_cfg_ready) are always taken and must
//   only be issued while the block is idle.
//   Reset loads the register defaults, empties the grid and drops all valids.
`include "lidar_bev_occupancy_grid_unit_macros.svh"

module lidar_bev_occupancy_grid_unit #(
    parameter int GRID_MAX = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lbev_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lbev_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [lbev_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [lbev_pkg::POS_W-1:0]     i_x_pos,
    input  logic signed [lbev_pkg::POS_W-1:0]     i_y_pos,
    input  logic [lbev_pkg::ROW_W-1:0]            i_read_row,
    // Output channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [lbev_pkg::ROW_W-1:0]            o_cell_row,
    output logic [lbev_pkg::ROW_W-1:0]            o_cell_col,
    output logic                                  o_in_range,
    output logic [lbev_pkg::BITS_W-1:0]           o_row_bits
);

    import lbev_pkg::*;

    localparam int AW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam logic [CELLS_W-1:0] GRID_LIM = CELLS_W'(GRID_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_IDX  = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    // Configuration registers.
    logic [CELLS_W-1:0] r_grid_cells;
    logic [RANGE_W-1:0] r_range_offset;
    logic [SCALE_W-1:0] r_cell_scale;

    // Control state.
    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [GRID_MAX-1:0] r_row_valid;
    logic                r_out_valid;

    // Item payload through the steps.
    t_item              r_item;
    logic [MAG_W-1:0]   r_mag_x;
    logic [MAG_W-1:0]   r_mag_y;
    logic               r_neg_x;
    logic               r_neg_y;
    logic [PROD_W-1:0]  r_prod_x;
    logic [PROD_W-1:0]  r_prod_y;
    logic               r_hit;
    logic               r_rd_ok;
    logic [AW-1:0]      r_addr;
    logic [ROW_W-1:0]   r_col;

    // Output register payload.
    logic [ROW_W-1:0]   r_cell_row;
    logic [ROW_W-1:0]   r_cell_col;
    logic               r_in_range;
    logic [BITS_W-1:0]  r_row_bits;

    logic                    in_acc;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [MAG_W-1:0]        q_x;
    logic [MAG_W-1:0]        q_y;
    logic [CELLS_W-1:0]      lim;
    logic                    row_ok;
    logic                    col_ok;
    logic                    hit;
    logic                    rd_ok;
    logic [AW-1:0]           rd_addr;
    logic                    out_load;
    logic [BITS_W-1:0]       old_row;
    logic [BITS_W-1:0]       ram_wdata;
    logic [BITS_W-1:0]       ram_rdata;
    logic                    ram_we;
    logic                    ram_re;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cells   <= GRID_CELLS_RST;
            r_range_offset <= RANGE_OFFSET_RST;
            r_cell_scale   <= CELL_SCALE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GRID_CELLS:   r_grid_cells   <= i_cfg_data[CELLS_W-1:0];
                REG_RANGE_OFFSET: r_range_offset <= i_cfg_data[RANGE_W-1:0];
                REG_CELL_SCALE:   r_cell_scale   <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // One item is in flight at a time; new transfers are taken only when idle.
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Position plus range as a 17-bit signed sum, split into sign and magnitude.
    assign sum_x = SUM_W'(i_x_pos) + $signed({2'b00, r_range_offset});
    assign sum_y = SUM_W'(i_y_pos) + $signed({2'b00, r_range_offset});

    // Grid index from the registered products; truncation toward zero means a
    // negative sum is only usable when its quotient is zero.
    assign q_x    = r_prod_x[SCALE_FRAC +: MAG_W];
    assign q_y    = r_prod_y[SCALE_FRAC +: MAG_W];
    assign lim    = (r_grid_cells > GRID_LIM) ? GRID_LIM : r_grid_cells;
    assign row_ok = (!r_neg_x || (q_x == '0)) && (q_x < MAG_W'(lim));
    assign col_ok = (!r_neg_y || (q_y == '0)) && (q_y < MAG_W'(lim));
    assign hit    = (r_item.func == FUNC_MARK) && row_ok && col_ok;
    assign rd_ok  = (r_item.func == FUNC_READ) && ({1'b0, r_item.read_row} < GRID_LIM);
    assign rd_addr = (r_item.func == FUNC_READ) ? r_item.read_row[AW-1:0] : q_x[AW-1:0];

    // Row merge and output load in the last step.
    assign out_load  = (r_state == ST_WB) && (!r_out_valid || !i_out_stall);
    assign old_row   = r_row_valid[r_addr] ? ram_rdata : '0;
    assign ram_wdata = old_row | (BITS_W'(1) << r_col);
    assign ram_we    = out_load && r_hit;
    assign ram_re    = (r_state == ST_IDX);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_MUL;
            ST_MUL:  n_state = ST_IDX;
            ST_IDX:  n_state = ST_WB;
            ST_WB:   if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers: state, row valid flags and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_item.func == FUNC_CLEAR) begin
                    r_row_valid <= '0;
                end else if (r_hit) begin
                    r_row_valid[r_addr] <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the item steps and the output register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.func     <= i_func;
            r_item.read_row <= i_read_row;
            r_neg_x         <= sum_x[SUM_W-1];
            r_neg_y         <= sum_y[SUM_W-1];
            r_mag_x         <= sum_x[SUM_W-1] ? MAG_W'(-sum_x) : MAG_W'(sum_x);
            r_mag_y         <= sum_y[SUM_W-1] ? MAG_W'(-sum_y) : MAG_W'(sum_y);
        end
        if (r_state == ST_MUL) begin
            r_prod_x <= PROD_W'(r_mag_x) * PROD_W'(r_cell_scale);
            r_prod_y <= PROD_W'(r_mag_y) * PROD_W'(r_cell_scale);
        end
        if (r_state == ST_IDX) begin
            r_hit   <= hit;
            r_rd_ok <= rd_ok;
            r_addr  <= rd_addr;
            r_col   <= hit ? q_y[ROW_W-1:0] : '0;
        end
        if (out_load) begin
            r_cell_row <= r_hit ? ROW_W'(r_addr) : '0;
            r_cell_col <= r_hit ? r_col : '0;
            r_in_range <= r_hit;
            r_row_bits <= r_rd_ok ? old_row : '0;
        end
    end

    // Occupancy rows.
    lbev_ram #(
        .WIDTH (BITS_W),
        .DEPTH (GRID_MAX)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_cell_row  = r_cell_row;
    assign o_cell_col  = r_cell_col;
    assign o_in_range  = r_in_range;
    assign o_row_bits  = r_row_bits;

    // Checks on sequencing, write-back and cell indexes.
    `LBEV_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == ST_MUL)
    `LBEV_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_state == ST_WB && r_out_valid && i_out_stall, r_state == ST_WB)
    `LBEV_ASSERT_IMPL(a_write_only_on_hit, i_clk, i_rst_n, ram_we, r_state == ST_WB && r_item.func == FUNC_MARK)
    `LBEV_ASSERT_IMPL(a_hit_in_grid, i_clk, i_rst_n, o_out_valid && o_in_range, CELLS_W'(o_cell_row) < GRID_LIM && CELLS_W'(o_cell_col) < GRID_LIM)

endmodule
